/* design/vtec_pkg.sv */
package vtec_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int MAX_VERTICES  = 1024;

    localparam int VIDX_W  = 10;
    localparam int TRI_AW  = 10;
    localparam int TCNT_W  = 11;
    localparam int CNT_W   = 12;
    localparam int OFF_AW  = 11;
    localparam int ELEM_DEPTH = 3 * MAX_TRIANGLES;
    localparam int ELEM_AW = 12;
    localparam int PTR_W   = 13;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_FETCH   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [1:0] KIND_OFFSET = 2'd0;
    localparam logic [1:0] KIND_ELEM   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [1:0] PHASE_LOADING  = 2'd0;
    localparam logic [1:0] PHASE_EMITTING = 2'd1;
    localparam logic [1:0] PHASE_DONE     = 2'd2;

    function automatic logic [VIDX_W-1:0] pick_vertex(input logic [3*VIDX_W-1:0] tri_word,
                                                     input logic [1:0] k);
        logic [VIDX_W-1:0] v;
        case (k)
            2'd0:    v = tri_word[VIDX_W-1:0];
            2'd1:    v = tri_word[2*VIDX_W-1:VIDX_W];
            default: v = tri_word[3*VIDX_W-1:2*VIDX_W];
        endcase
        return v;
    endfunction

endpackage

/* design/vertex_to_element_connectivity.sv */
// vertex-to-element connectivity builder (csr transpose by counting sort)
// input channel s_*: one request per item; s_cmd selects load triangle,
// fetch next result word or restart. result channel m_*: kind, value, last.
// a load is accepted, then reads and writes back the use counter of each of
// its three vertices in the counter memory.
// a restart clears the used counters.
// the first fetch after loading builds the map: a prefix sum over the vertex
// counters, a scatter over the triangles, then the word.
// every other fetch passes accept, memory read and output register; a rejected
// load passes accept and output register. both wait while the output is full.
// fetches past the end and loads that are kept produce no result.
// after reset the counter memory is cleared over all its entries; s_ready is low
// during that pass and the cycle after it. s_ready is high whenever the engine
// is idle, so a new request is taken while a result still waits in the output
// register; if m_ready stays low, the next result-producing request waits.
module vertex_to_element_connectivity (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [9:0]  s_first_vertex,
    input  logic [9:0]  s_second_vertex,
    input  logic [9:0]  s_third_vertex,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [11:0] m_value,
    output logic        m_last
);

    localparam int VW = vtec_pkg::VIDX_W;
    localparam int TW = vtec_pkg::TCNT_W;
    localparam int CW = vtec_pkg::CNT_W;
    localparam int OW = vtec_pkg::OFF_AW;
    localparam int EW = vtec_pkg::ELEM_AW;
    localparam int PW = vtec_pkg::PTR_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_LD_RD  = 4'd2;
    localparam logic [3:0] S_LD_WR  = 4'd3;
    localparam logic [3:0] S_PRE_RD = 4'd4;
    localparam logic [3:0] S_PRE_WR = 4'd5;
    localparam logic [3:0] S_SC_TRI = 4'd6;
    localparam logic [3:0] S_SC_RD  = 4'd7;
    localparam logic [3:0] S_SC_WR  = 4'd8;
    localparam logic [3:0] S_EM_RD  = 4'd9;
    localparam logic [3:0] S_EM_OUT = 4'd10;
    localparam logic [3:0] S_REJ    = 4'd11;

    // memories
    logic [3*VW-1:0] tri_mem  [vtec_pkg::MAX_TRIANGLES];
    logic [CW-1:0]   cnt_mem  [vtec_pkg::MAX_VERTICES];
    logic [CW-1:0]   off_mem  [vtec_pkg::MAX_VERTICES+1];
    logic [VW-1:0]   elem_mem [vtec_pkg::ELEM_DEPTH];

    logic [3*VW-1:0] tri_q;
    logic [CW-1:0]   cnt_q;
    logic [CW-1:0]   off_q;
    logic [VW-1:0]   elem_q;

    logic            tri_we;
    logic [VW-1:0]   tri_waddr;
    logic [3*VW-1:0] tri_wdata;
    logic            cnt_we;
    logic [VW-1:0]   cnt_waddr;
    logic [CW-1:0]   cnt_wdata;
    logic [VW-1:0]   cnt_raddr;
    logic            off_we;
    logic [OW-1:0]   off_waddr;
    logic [CW-1:0]   off_wdata;
    logic            off_re;
    logic [OW-1:0]   off_raddr;
    logic            elem_we;
    logic [EW-1:0]   elem_waddr;
    logic [VW-1:0]   elem_wdata;
    logic            elem_re;
    logic [EW-1:0]   elem_raddr;

    // control and payload registers
    logic [3:0]      state_reg, state_next;
    logic [1:0]      phase_reg, phase_next;
    logic [TW-1:0]   tcount_reg, tcount_next;
    logic [TW-1:0]   hv_reg, hv_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [TW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [TW-1:0]   clr_end_reg, clr_end_next;
    logic [1:0]      k_reg, k_next;
    logic [3*VW-1:0] ld_v_reg, ld_v_next;
    logic [TW-1:0]   pv_reg, pv_next;
    logic [CW-1:0]   run_reg, run_next;
    logic [TW-1:0]   sc_t_reg, sc_t_next;
    logic [1:0]      em_kind_reg, em_kind_next;
    logic            em_last_reg, em_last_next;
    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_kind_reg, m_kind_next;
    logic [11:0]     m_value_reg, m_value_next;
    logic            m_last_reg, m_last_next;

    logic            accept;
    logic            out_free;
    logic            bad_vertex;
    logic [VW-1:0]   top;
    logic [PW-1:0]   total;
    logic [PW-1:0]   rp_inc;
    logic [VW-1:0]   ld_vx;
    logic [VW-1:0]   sc_vx;
    logic [CW-1:0]   run_sum;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

    assign bad_vertex = ({1'b0, s_first_vertex}  >= TW'(vtec_pkg::MAX_VERTICES)) ||
                        ({1'b0, s_second_vertex} >= TW'(vtec_pkg::MAX_VERTICES)) ||
                        ({1'b0, s_third_vertex}  >= TW'(vtec_pkg::MAX_VERTICES));

    always_comb begin
        top = s_first_vertex;
        if (s_second_vertex > top) begin
            top = s_second_vertex;
        end
        if (s_third_vertex > top) begin
            top = s_third_vertex;
        end
    end

    assign total   = PW'(hv_reg) + PW'(1) + PW'({tcount_reg, 1'b0}) + PW'(tcount_reg);
    assign rp_inc  = rp_reg + PW'(1);
    assign ld_vx   = vtec_pkg::pick_vertex(ld_v_reg, k_reg);
    assign sc_vx   = vtec_pkg::pick_vertex(tri_q, k_reg);
    assign run_sum = run_reg + cnt_q;

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        tcount_next  = tcount_reg;
        hv_next      = hv_reg;
        rp_next      = rp_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_end_next = clr_end_reg;
        k_next       = k_reg;
        ld_v_next    = ld_v_reg;
        pv_next      = pv_reg;
        run_next     = run_reg;
        sc_t_next    = sc_t_reg;
        em_kind_next = em_kind_reg;
        em_last_next = em_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;

        tri_we     = 1'b0;
        tri_waddr  = tcount_reg[VW-1:0];
        tri_wdata  = {s_third_vertex, s_second_vertex, s_first_vertex};
        cnt_we     = 1'b0;
        cnt_waddr  = clr_cnt_reg[VW-1:0];
        cnt_wdata  = '0;
        cnt_raddr  = ld_vx;
        off_we     = 1'b0;
        off_waddr  = '0;
        off_wdata  = '0;
        off_re     = 1'b0;
        off_raddr  = rp_reg[OW-1:0];
        elem_we    = 1'b0;
        elem_waddr = cnt_q;
        elem_wdata = sc_t_reg[VW-1:0];
        elem_re    = 1'b0;
        elem_raddr = EW'(rp_reg - PW'(hv_reg) - PW'(1));

        case (state_reg)
            S_CLR: begin
                if (clr_cnt_reg == clr_end_reg) begin
                    state_next = S_IDLE;
                end else begin
                    cnt_we       = 1'b1;
                    clr_cnt_next = clr_cnt_reg + TW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        vtec_pkg::CMD_LOAD: begin
                            if (phase_reg != vtec_pkg::PHASE_LOADING ||
                                tcount_reg == TW'(vtec_pkg::MAX_TRIANGLES) || bad_vertex) begin
                                state_next = S_REJ;
                            end else begin
                                tri_we      = 1'b1;
                                tcount_next = tcount_reg + TW'(1);
                                ld_v_next   = {s_third_vertex, s_second_vertex, s_first_vertex};
                                k_next      = 2'd0;
                                if ({1'b0, top} + TW'(1) > hv_reg) begin
                                    hv_next = {1'b0, top} + TW'(1);
                                end
                                state_next  = S_LD_RD;
                            end
                        end
                        vtec_pkg::CMD_FETCH: begin
                            if (phase_reg == vtec_pkg::PHASE_LOADING) begin
                                off_we     = 1'b1;
                                pv_next    = '0;
                                run_next   = '0;
                                state_next = S_PRE_RD;
                            end else if (phase_reg == vtec_pkg::PHASE_EMITTING) begin
                                state_next = S_EM_RD;
                            end
                        end
                        vtec_pkg::CMD_RESTART: begin
                            clr_cnt_next = '0;
                            clr_end_next = hv_reg;
                            tcount_next  = '0;
                            hv_next      = '0;
                            rp_next      = '0;
                            phase_next   = vtec_pkg::PHASE_LOADING;
                            state_next   = S_CLR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LD_RD: begin
                cnt_raddr  = ld_vx;
                state_next = S_LD_WR;
            end
            S_LD_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = ld_vx;
                cnt_wdata = cnt_q + CW'(1);
                if (k_reg == 2'd2) begin
                    state_next = S_IDLE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_LD_RD;
                end
            end
            S_PRE_RD: begin
                cnt_raddr = pv_reg[VW-1:0];
                if (pv_reg == hv_reg) begin
                    sc_t_next = '0;
                    k_next    = 2'd0;
                    if (tcount_reg == '0) begin
                        phase_next = vtec_pkg::PHASE_EMITTING;
                        rp_next    = '0;
                        state_next = S_EM_RD;
                    end else begin
                        state_next = S_SC_TRI;
                    end
                end else begin
                    state_next = S_PRE_WR;
                end
            end
            S_PRE_WR: begin
                off_we     = 1'b1;
                off_waddr  = pv_reg + OW'(1);
                off_wdata  = run_sum;
                cnt_we     = 1'b1;
                cnt_waddr  = pv_reg[VW-1:0];
                cnt_wdata  = run_reg;
                run_next   = run_sum;
                pv_next    = pv_reg + TW'(1);
                state_next = S_PRE_RD;
            end
            S_SC_TRI: begin
                state_next = S_SC_RD;
            end
            S_SC_RD: begin
                cnt_raddr  = sc_vx;
                state_next = S_SC_WR;
            end
            S_SC_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = sc_vx;
                cnt_wdata = cnt_q + CW'(1);
                elem_we   = (cnt_q < CW'(vtec_pkg::ELEM_DEPTH));
                if (k_reg == 2'd2) begin
                    k_next    = 2'd0;
                    sc_t_next = sc_t_reg + TW'(1);
                    if (sc_t_reg + TW'(1) == tcount_reg) begin
                        phase_next = vtec_pkg::PHASE_EMITTING;
                        rp_next    = '0;
                        state_next = S_EM_RD;
                    end else begin
                        state_next = S_SC_TRI;
                    end
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_SC_RD;
                end
            end
            S_EM_RD: begin
                if (rp_reg <= PW'(hv_reg)) begin
                    off_re       = 1'b1;
                    em_kind_next = vtec_pkg::KIND_OFFSET;
                end else begin
                    elem_re      = 1'b1;
                    em_kind_next = vtec_pkg::KIND_ELEM;
                end
                em_last_next = (rp_inc >= total);
                rp_next      = rp_inc;
                if (rp_inc >= total) begin
                    phase_next = vtec_pkg::PHASE_DONE;
                end
                state_next = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = em_kind_reg;
                    m_value_next = (em_kind_reg == vtec_pkg::KIND_OFFSET) ? off_q
                                                                          : {2'b00, elem_q};
                    m_last_next  = em_last_reg;
                    state_next   = S_IDLE;
                end
            end
            S_REJ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = vtec_pkg::KIND_REJECT;
                    m_value_next = '0;
                    m_last_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tri_we) begin
            tri_mem[tri_waddr] <= tri_wdata;
        end
        tri_q <= tri_mem[sc_t_reg[VW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[off_waddr] <= off_wdata;
        end
        if (off_re) begin
            off_q <= off_mem[off_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_waddr] <= elem_wdata;
        end
        if (elem_re) begin
            elem_q <= elem_mem[elem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            phase_reg   <= vtec_pkg::PHASE_LOADING;
            tcount_reg  <= '0;
            hv_reg      <= '0;
            rp_reg      <= '0;
            clr_cnt_reg <= '0;
            clr_end_reg <= TW'(vtec_pkg::MAX_VERTICES);
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            tcount_reg  <= tcount_next;
            hv_reg      <= hv_next;
            rp_reg      <= rp_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_end_reg <= clr_end_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ld_v_reg    <= ld_v_next;
        pv_reg      <= pv_next;
        run_reg     <= run_next;
        sc_t_reg    <= sc_t_next;
        em_kind_reg <= em_kind_next;
        em_last_reg <= em_last_next;
        m_kind_reg  <= m_kind_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

endmodule
